### rtl/core/mp2fhd_pkg.sv
// Shared types, constants and lookup tables for the MPEG audio layer II header decoder.
// No dependencies; used by every module under rtl/core.
package mp2fhd_pkg;

  localparam logic [10:0] SYNC_WORD   = 11'h7ff;
  localparam logic [1:0]  VER_MPEG1   = 2'b11;
  localparam logic [1:0]  VER_MPEG2   = 2'b10;
  localparam logic [1:0]  LAYER_II    = 2'b10;
  localparam logic [3:0]  BRI_FREE    = 4'd0;
  localparam logic [3:0]  BRI_BAD     = 4'd15;
  localparam logic [1:0]  SRI_RSVD    = 2'd3;
  localparam logic [1:0]  MODE_MONO   = 2'd3;

  localparam int          KBPS_W      = 9;
  localparam int          RATE_W      = 16;
  localparam int          SIZE_W      = 11;
  localparam int          NUM_W       = 16;
  localparam int          RECIP_W     = 17;
  localparam int          PROD_W      = NUM_W + RECIP_W;
  localparam int          RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_49 = 17'd85599;
  localparam logic [SIZE_W-1:0]  HDR_BYTES = 11'd4;

  typedef enum logic [2:0] {
    QS_RECIP49,
    QS_X3,
    QS_X4P5,
    QS_X6,
    QS_X9
  } qsel_t;

  typedef struct packed {
    logic              valid_res;
    logic              is_mpeg1;
    logic [RATE_W-1:0] sample_rate;
    logic [KBPS_W-1:0] bitrate_kbps;
    logic              stereo;
    logic              padded;
    logic              has_checksum;
  } hdr_t;

  typedef struct packed {
    hdr_t             hdr;
    qsel_t            qsel;
    logic [NUM_W-1:0] num;
  } s1_t;

  typedef struct packed {
    hdr_t              hdr;
    qsel_t             qsel;
    logic [SIZE_W-1:0] q_dir;
    logic [SIZE_W-1:0] q_rec;
  } s2_t;

  typedef struct packed {
    hdr_t              hdr;
    logic [SIZE_W-1:0] frame_bytes;
  } s3_t;

  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic mpeg1, input logic [3:0] bri);
    logic [KBPS_W-1:0] k;
    k = '0;
    if (mpeg1) begin
      unique case (bri)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd48;
        4'd3:    k = 9'd56;
        4'd4:    k = 9'd64;
        4'd5:    k = 9'd80;
        4'd6:    k = 9'd96;
        4'd7:    k = 9'd112;
        4'd8:    k = 9'd128;
        4'd9:    k = 9'd160;
        4'd10:   k = 9'd192;
        4'd11:   k = 9'd224;
        4'd12:   k = 9'd256;
        4'd13:   k = 9'd320;
        4'd14:   k = 9'd384;
        default: k = '0;
      endcase
    end else begin
      unique case (bri)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [RATE_W-1:0] rate_lookup(input logic mpeg1, input logic [1:0] sri);
    logic [RATE_W-1:0] r;
    unique case ({mpeg1, sri})
      3'b100:  r = 16'd44100;
      3'b101:  r = 16'd48000;
      3'b110:  r = 16'd32000;
      3'b000:  r = 16'd22050;
      3'b001:  r = 16'd24000;
      3'b010:  r = 16'd16000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic qsel_t qsel_lookup(input logic mpeg1, input logic [1:0] sri);
    qsel_t q;
    unique case ({mpeg1, sri})
      3'b101:  q = QS_X3;
      3'b110:  q = QS_X4P5;
      3'b001:  q = QS_X6;
      3'b010:  q = QS_X9;
      default: q = QS_RECIP49;
    endcase
    return q;
  endfunction

endpackage

### rtl/core/mp2fhd_parse.sv
// Stage 1: header field checks, rate and bitrate tables, divide-by-49 numerator.
// Depends on mp2fhd_pkg.
module mp2fhd_parse import mp2fhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] header_word,
  output logic        v_r,
  output s1_t         s1_r
);

  logic        ok;
  logic        mpeg1;
  logic [KBPS_W-1:0] kbps;
  s1_t         s1_nxt;

  always_comb begin
    mpeg1 = (header_word[20:19] == VER_MPEG1);
    ok = (header_word[31:21] == SYNC_WORD)
      && ((header_word[20:19] == VER_MPEG1) || (header_word[20:19] == VER_MPEG2))
      && (header_word[18:17] == LAYER_II)
      && (header_word[15:12] != BRI_FREE)
      && (header_word[15:12] != BRI_BAD)
      && (header_word[11:10] != SRI_RSVD);
    kbps = kbps_lookup(mpeg1, header_word[15:12]);
    s1_nxt = '0;
    s1_nxt.qsel = qsel_lookup(mpeg1, header_word[11:10]);
    if (ok) begin
      s1_nxt.hdr.valid_res    = 1'b1;
      s1_nxt.hdr.is_mpeg1     = mpeg1;
      s1_nxt.hdr.sample_rate  = rate_lookup(mpeg1, header_word[11:10]);
      s1_nxt.hdr.bitrate_kbps = kbps;
      s1_nxt.hdr.stereo       = (header_word[7:6] != MODE_MONO);
      s1_nxt.hdr.padded       = header_word[9];
      s1_nxt.hdr.has_checksum = !header_word[16];
    end
    // 44100 Hz: k*160/49; 22050 Hz: k*320/49; elsewhere only k is needed
    if (s1_nxt.qsel == QS_RECIP49) begin
      if (mpeg1) begin
        s1_nxt.num = ({7'd0, kbps} << 7) + ({7'd0, kbps} << 5);
      end else begin
        s1_nxt.num = ({7'd0, kbps} << 8) + ({7'd0, kbps} << 6);
      end
    end else begin
      s1_nxt.num = {7'd0, kbps};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_v) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### rtl/core/mp2fhd_quot.sv
// Stage 2: reciprocal multiply for the divide by 49 and shift-add quotients for other rates.
// Depends on mp2fhd_pkg.
module mp2fhd_quot import mp2fhd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  s1_t  s1,
  output logic v_r,
  output s2_t  s2_r
);

  logic [PROD_W-1:0] prod;
  logic [11:0]       k12;
  logic [11:0]       k9;
  s2_t               s2_nxt;

  always_comb begin
    prod = {{RECIP_W{1'b0}}, s1.num} * {{NUM_W{1'b0}}, RECIP_49};
    k12  = s1.num[11:0];
    k9   = (k12 << 3) + k12;
    s2_nxt.hdr   = s1.hdr;
    s2_nxt.qsel  = s1.qsel;
    s2_nxt.q_rec = prod[RECIP_SHIFT +: SIZE_W];
    unique case (s1.qsel)
      QS_X3:   s2_nxt.q_dir = SIZE_W'((k12 << 1) + k12);
      QS_X4P5: s2_nxt.q_dir = k9[11:1];
      QS_X6:   s2_nxt.q_dir = SIZE_W'((k12 << 2) + (k12 << 1));
      QS_X9:   s2_nxt.q_dir = k9[SIZE_W-1:0];
      default: s2_nxt.q_dir = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_v) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

### rtl/core/mp2fhd_size.sv
// Stage 3: quotient select, header and flag adjustment, output register.
// Depends on mp2fhd_pkg.
module mp2fhd_size import mp2fhd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  s2_t  s2,
  output logic v_r,
  output s3_t  s3_r
);

  logic [SIZE_W-1:0] q;
  s3_t               s3_nxt;

  always_comb begin
    q = (s2.qsel == QS_RECIP49) ? s2.q_rec : s2.q_dir;
    s3_nxt.hdr = s2.hdr;
    if (s2.hdr.valid_res) begin
      s3_nxt.frame_bytes = q - HDR_BYTES
                         + {{(SIZE_W-1){1'b0}}, s2.hdr.padded}
                         + {{(SIZE_W-2){1'b0}}, s2.hdr.has_checksum, 1'b0};
    end else begin
      s3_nxt.frame_bytes = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_v) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

### rtl/core/mp2_frame_header_decode.sv
// MPEG audio layer II frame header decoder, top level.
// Stages: parse, multiply and size, each registered, from input transaction to result.
// Throughput: one transaction per cycle when out_stall is low; a stage advances when empty
// or when the next one advances, so bubbles are absorbed; in_stall follows out_stall combinationally.
// Reset: rst_n synchronous, clears the stage valid bits only.
// Depends on mp2fhd_pkg, mp2fhd_parse, mp2fhd_quot, mp2fhd_size.
module mp2_frame_header_decode import mp2fhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_header_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic        out_is_mpeg1,
  output logic [15:0] out_sample_rate,
  output logic [8:0]  out_bitrate_kbps,
  output logic        out_stereo,
  output logic        out_padded,
  output logic        out_has_checksum,
  output logic [10:0] out_frame_bytes
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  s1_t  s1_r;
  s2_t  s2_r;
  s3_t  s3_r;

  // advance a stage when it is empty or its successor advances
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  mp2fhd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en1),
    .in_v        (in_valid),
    .header_word (in_header_word),
    .v_r         (v1_r),
    .s1_r        (s1_r)
  );

  mp2fhd_quot u_quot (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en2),
    .in_v  (v1_r),
    .s1    (s1_r),
    .v_r   (v2_r),
    .s2_r  (s2_r)
  );

  mp2fhd_size u_size (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en3),
    .in_v  (v2_r),
    .s2    (s2_r),
    .v_r   (v3_r),
    .s3_r  (s3_r)
  );

  assign out_valid        = v3_r;
  assign out_valid_res    = s3_r.hdr.valid_res;
  assign out_is_mpeg1     = s3_r.hdr.is_mpeg1;
  assign out_sample_rate  = s3_r.hdr.sample_rate;
  assign out_bitrate_kbps = s3_r.hdr.bitrate_kbps;
  assign out_stereo       = s3_r.hdr.stereo;
  assign out_padded       = s3_r.hdr.padded;
  assign out_has_checksum = s3_r.hdr.has_checksum;
  assign out_frame_bytes  = s3_r.frame_bytes;

endmodule
